### hw/rtl/assert_macros.svh
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define ASSERT_IMPL(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/ftcm_pkg.sv
package ftcm_pkg;

  // default fraction width of the datapath
  localparam int unsigned WIDTH_DEF = 16;

  // fixed port widths
  localparam int unsigned DATA_W = 16;
  localparam int unsigned TWR_W  = 17;

  // how the output stage forms the result
  typedef enum logic [1:0] {
    MODE_MUL,
    MODE_UNITY,
    MODE_MINUS_J
  } mode_e;

endpackage

### hw/rtl/ftcm_cell.sv
module ftcm_cell
  import ftcm_pkg::*;
#(
  parameter int unsigned W    = WIDTH_DEF,
  parameter bit          LAST = 1'b0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         ready_i,
  input  mode_e        mode_i,
  input  logic [W-1:0] a_r_i,
  input  logic [W-1:0] a_i_i,
  input  logic [W-1:0] b_r_i,
  input  logic [W-1:0] b_i_i,
  input  logic [W:0]   pp_rr_i,
  input  logic [W:0]   pp_ii_i,
  input  logic [W:0]   pp_ri_i,
  input  logic [W:0]   pp_ir_i,
  output mode_e        mode_o,
  output logic [W-1:0] a_r_o,
  output logic [W-1:0] a_i_o,
  output logic [W-1:0] b_r_o,
  output logic [W-1:0] b_i_o,
  output logic [W:0]   pp_rr_o,
  output logic [W:0]   pp_ii_o,
  output logic [W:0]   pp_ri_o,
  output logic [W:0]   pp_ir_o
);

  logic         valid_q;
  mode_e        mode_q;
  logic [W-1:0] a_r_q, a_i_q, b_r_q, b_i_q;
  logic [W:0]   pp_rr_q, pp_ii_q, pp_ri_q, pp_ir_q;
  logic [W:0]   pp_rr_d, pp_ii_d, pp_ri_d, pp_ir_d;
  logic         load;

  // one shift-add step; the last cell adds the inverted multiplicand plus one
  function automatic logic [W:0] step(logic [W:0] pp, logic [W-1:0] a, logic b0);
    logic [W:0] addend;
    logic [W:0] sum;
    logic [W:0] res;
    addend = '0;
    if (b0) begin
      addend = LAST ? {~a, 1'b0} : {a, 1'b0};
    end
    sum = pp + addend;
    res = sum >> 1;
    if (LAST) begin
      res = {1'b0, res[W-1:0] + {{(W-1){1'b0}}, b0}};
    end else begin
      res[W] = res[W-1];
    end
    return res;
  endfunction

  // advance when empty or when the neighbor takes our word
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // partial products of the four real multiplies
  always_comb begin
    pp_rr_d = step(pp_rr_i, a_r_i, b_r_i[0]);
    pp_ii_d = step(pp_ii_i, a_i_i, b_i_i[0]);
    pp_ri_d = step(pp_ri_i, a_r_i, b_i_i[0]);
    pp_ir_d = step(pp_ir_i, a_i_i, b_r_i[0]);
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload, multiplier bits shift down one place per cell
  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q  <= mode_i;
      a_r_q   <= a_r_i;
      a_i_q   <= a_i_i;
      b_r_q   <= b_r_i >> 1;
      b_i_q   <= b_i_i >> 1;
      pp_rr_q <= pp_rr_d;
      pp_ii_q <= pp_ii_d;
      pp_ri_q <= pp_ri_d;
      pp_ir_q <= pp_ir_d;
    end
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  assign a_r_o   = a_r_q;
  assign a_i_o   = a_i_q;
  assign b_r_o   = b_r_q;
  assign b_i_o   = b_i_q;
  assign pp_rr_o = pp_rr_q;
  assign pp_ii_o = pp_ii_q;
  assign pp_ri_o = pp_ri_q;
  assign pp_ir_o = pp_ir_q;

endmodule

### hw/rtl/ftcm_out.sv
module ftcm_out
  import ftcm_pkg::*;
#(
  parameter int unsigned W = WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  mode_e                    mode_i,
  input  logic [W-1:0]             a_r_i,
  input  logic [W-1:0]             a_i_i,
  input  logic [W-1:0]             rr_i,
  input  logic [W-1:0]             ii_i,
  input  logic [W-1:0]             ri_i,
  input  logic [W-1:0]             ir_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] prod_real_o,
  output logic signed [DATA_W-1:0] prod_imag_o
);

  logic                     valid_q;
  logic signed [W-1:0]      pr, pi;
  logic signed [DATA_W-1:0] prod_real_q, prod_imag_q;

  // combine the real products or take a special case
  always_comb begin
    unique case (mode_i)
      MODE_UNITY: begin
        pr = a_r_i;
        pi = a_i_i;
      end
      MODE_MINUS_J: begin
        pr = a_i_i;
        pi = W'(0) - a_r_i;
      end
      default: begin
        pr = rr_i - ii_i;
        pi = ri_i + ir_i;
      end
    endcase
  end

  assign ready_o = !valid_q || out_ready_i;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // output word, sign-extended or cut to the port width
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_real_q <= DATA_W'(pr);
      prod_imag_q <= DATA_W'(pi);
    end
  end

  assign out_valid_o = valid_q;
  assign prod_real_o = prod_real_q;
  assign prod_imag_o = prod_imag_q;

endmodule

### hw/rtl/fixed_point_twiddle_complex_mul_top.sv
// Complex multiplier for FFT twiddle factors, signed fractions of WIDTH bits.
// Input channel: in_valid_i / in_ready_o carry one word of data_real_i,
// data_imag_i, twiddle_real_i and twiddle_imag_i. Output channel:
// out_valid_o / out_ready_i carry prod_real_o and prod_imag_o.
// The four real products are shift-add multiplies run down a row of WIDTH
// cells, one multiplier bit per cell, the last cell doing the sign step.
// A registered output stage forms rr - ii and ri + ir or takes the unity
// or minus-j shortcut.
// An accepted word passes through the WIDTH cells and then the output register.
// Throughput: one word per cycle while out_ready_i is high; every cell and the
// output register hold a word, so up to WIDTH + 1 words are in flight.
// When the receiver stalls, words pile up behind the output register and
// empty cells keep filling; in_ready_o falls only once every stage is full.
// Reset (rst_ni low, asynchronous) empties all stages; no word survives.
module fixed_point_twiddle_complex_mul_top
  import ftcm_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] data_real_i,
  input  logic signed [DATA_W-1:0] data_imag_i,
  input  logic signed [TWR_W-1:0]  twiddle_real_i,
  input  logic signed [DATA_W-1:0] twiddle_imag_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] prod_real_o,
  output logic signed [DATA_W-1:0] prod_imag_o
);

`include "assert_macros.svh"

  localparam logic signed [31:0] HALF = 32'sd1 <<< (WIDTH - 1);

  logic             valid_s [WIDTH+1];
  logic             ready_s [WIDTH+1];
  mode_e            mode_s  [WIDTH+1];
  logic [WIDTH-1:0] ar_s    [WIDTH+1];
  logic [WIDTH-1:0] ai_s    [WIDTH+1];
  logic [WIDTH-1:0] br_s    [WIDTH+1];
  logic [WIDTH-1:0] bi_s    [WIDTH+1];
  logic [WIDTH:0]   rr_s    [WIDTH+1];
  logic [WIDTH:0]   ii_s    [WIDTH+1];
  logic [WIDTH:0]   ri_s    [WIDTH+1];
  logic [WIDTH:0]   ir_s    [WIDTH+1];
  logic [WIDTH:0]   cells_full;
  logic signed [31:0] tr_ext, ti_ext;
  mode_e            in_mode;

  // twiddle classification
  assign tr_ext = 32'(twiddle_real_i);
  assign ti_ext = 32'(twiddle_imag_i);

  always_comb begin
    priority if (tr_ext == HALF && ti_ext == 32'sd0) begin
      in_mode = MODE_UNITY;
    end else if (tr_ext == 32'sd0 && ti_ext == -HALF) begin
      in_mode = MODE_MINUS_J;
    end else begin
      in_mode = MODE_MUL;
    end
  end

  // head of the row: operands reduced to WIDTH bits, products cleared
  assign valid_s[0] = in_valid_i;
  assign in_ready_o = ready_s[0];
  assign mode_s[0]  = in_mode;
  assign ar_s[0]    = WIDTH'(data_real_i);
  assign ai_s[0]    = WIDTH'(data_imag_i);
  assign br_s[0]    = WIDTH'(twiddle_real_i);
  assign bi_s[0]    = WIDTH'(twiddle_imag_i);
  assign rr_s[0]    = '0;
  assign ii_s[0]    = '0;
  assign ri_s[0]    = '0;
  assign ir_s[0]    = '0;

  // row of shift-add cells
  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    ftcm_cell #(
      .W    (WIDTH),
      .LAST (1'(k == WIDTH - 1))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .mode_i  (mode_s[k]),
      .a_r_i   (ar_s[k]),
      .a_i_i   (ai_s[k]),
      .b_r_i   (br_s[k]),
      .b_i_i   (bi_s[k]),
      .pp_rr_i (rr_s[k]),
      .pp_ii_i (ii_s[k]),
      .pp_ri_i (ri_s[k]),
      .pp_ir_i (ir_s[k]),
      .mode_o  (mode_s[k+1]),
      .a_r_o   (ar_s[k+1]),
      .a_i_o   (ai_s[k+1]),
      .b_r_o   (br_s[k+1]),
      .b_i_o   (bi_s[k+1]),
      .pp_rr_o (rr_s[k+1]),
      .pp_ii_o (ii_s[k+1]),
      .pp_ri_o (ri_s[k+1]),
      .pp_ir_o (ir_s[k+1])
    );
  end

  // combine and output register
  ftcm_out #(
    .W (WIDTH)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_s[WIDTH]),
    .ready_o     (ready_s[WIDTH]),
    .mode_i      (mode_s[WIDTH]),
    .a_r_i       (ar_s[WIDTH]),
    .a_i_i       (ai_s[WIDTH]),
    .rr_i        (rr_s[WIDTH][WIDTH-1:0]),
    .ii_i        (ii_s[WIDTH][WIDTH-1:0]),
    .ri_i        (ri_s[WIDTH][WIDTH-1:0]),
    .ir_i        (ir_s[WIDTH][WIDTH-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .prod_real_o (prod_real_o),
    .prod_imag_o (prod_imag_o)
  );

  // occupancy of every stage, for the checks below
  always_comb begin
    for (int k = 0; k < WIDTH; k++) begin
      cells_full[k] = valid_s[k+1];
    end
    cells_full[WIDTH] = out_valid_o;
  end

  // input stalls only with every stage full
  `ASSERT_IMPL(a_stall_full, clk_i, rst_ni, !in_ready_o, &cells_full)
  // an accepted word lands in the first cell
  `ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, in_valid_i && in_ready_o, valid_s[1])
  // a finished word moves into an empty output register
  `ASSERT_NEXT(a_drain_out, clk_i, rst_ni, valid_s[WIDTH] && !out_valid_o, out_valid_o)

endmodule

### tb/fixed_point_twiddle_complex_mul_top_tb.sv
`timescale 1ns / 1ps

module fixed_point_twiddle_complex_mul_top_tb;
  import ftcm_pkg::*;

  localparam int unsigned W        = WIDTH_DEF;
  localparam int unsigned LATENCY  = W + 1;
  localparam int          HALF     = 1 << (W - 1);
  localparam int unsigned N_RANDOM = 1900;

  // expected product of one word
  typedef struct packed {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
  } cplx_prod_t;

  // predicts every accepted word and checks the products in order
  class twiddle_scoreboard;
    cplx_prod_t  pending_prod_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    // shift-add multiply, one low bit dropped per step, sign bit by negation
    function logic [W-1:0] shift_add_mul(logic [W-1:0] mcand, logic [W-1:0] mplier);
      logic [W:0] acc;
      logic [W:0] addend;
      acc    = mplier[0] ? {1'b0, mcand} : '0;
      acc[W] = acc[W-1];
      for (int i = 1; i < W - 1; i++) begin
        addend = mplier[i] ? {mcand, 1'b0} : '0;
        acc    = acc + addend;
        acc    = acc >> 1;
        acc[W] = acc[W-1];
      end
      // sign step: add one's complement now, the +1 after the shift
      addend = mplier[W-1] ? {~mcand, 1'b0} : '0;
      acc    = acc + addend;
      acc    = acc >> 1;
      return acc[W-1:0] + {{(W-1){1'b0}}, mplier[W-1]};
    endfunction

    // accepted input word: work out its product
    function void note_word(logic signed [DATA_W-1:0] dr, logic signed [DATA_W-1:0] di,
                            logic signed [TWR_W-1:0] tr, logic signed [DATA_W-1:0] ti);
      int            tr_v;
      int            ti_v;
      logic  [W-1:0] rr, ii, ri, ir;
      logic  [W-1:0] tw_re;
      cplx_prod_t    p;
      tr_v  = int'(tr);
      ti_v  = int'(ti);
      tw_re = tr[W-1:0];
      if (tr_v == HALF && ti_v == 0) begin
        // unity twiddle passes the data through
        p.re = dr;
        p.im = di;
      end else if (tr_v == 0 && ti_v == -HALF) begin
        // minus-j twiddle swaps and negates, negation wraps
        p.re = di;
        p.im = -dr;
      end else begin
        rr   = shift_add_mul(dr, tw_re);
        ii   = shift_add_mul(di, ti);
        ri   = shift_add_mul(dr, ti);
        ir   = shift_add_mul(di, tw_re);
        p.re = rr - ii;
        p.im = ri + ir;
      end
      pending_prod_q.push_back(p);
    endfunction

    // accepted output word: compare with the oldest prediction
    function void check_result(logic [DATA_W-1:0] re, logic [DATA_W-1:0] im);
      cplx_prod_t p;
      checked++;
      if (pending_prod_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected product re=%h im=%h", $time, re, im);
        return;
      end
      p = pending_prod_q.pop_front();
      if (re !== p.re) begin
        mismatches++;
        $display("%0t: prod_real expected %h actual %h", $time, p.re, re);
      end
      if (im !== p.im) begin
        mismatches++;
        $display("%0t: prod_imag expected %h actual %h", $time, p.im, im);
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] data_real_i;
  logic signed [DATA_W-1:0] data_imag_i;
  logic signed [TWR_W-1:0]  twiddle_real_i;
  logic signed [DATA_W-1:0] twiddle_imag_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] prod_real_o;
  logic signed [DATA_W-1:0] prod_imag_o;

  twiddle_scoreboard sb = new();
  bit                burst_mode;

  fixed_point_twiddle_complex_mul_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_real_i   (data_real_i),
    .data_imag_i   (data_imag_i),
    .twiddle_real_i(twiddle_real_i),
    .twiddle_imag_i(twiddle_imag_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .prod_real_o   (prod_real_o),
    .prod_imag_o   (prod_imag_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // fraction with a bias toward the extremes
  function automatic logic [DATA_W-1:0] rand_frac();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // twiddle real part over its whole range, -HALF to +HALF
  function automatic logic [TWR_W-1:0] rand_tw_re();
    int v;
    case ($urandom_range(15))
      0:       v = HALF;
      1:       v = -HALF;
      2:       v = HALF - 1;
      3:       v = 0;
      default: v = int'($urandom_range(2 * HALF)) - HALF;
    endcase
    return v[TWR_W-1:0];
  endfunction

  // offer one word after an idle gap and hold it until accepted
  task automatic send_word(logic [DATA_W-1:0] dr, logic [DATA_W-1:0] di,
                           logic [TWR_W-1:0] tr, logic [DATA_W-1:0] ti);
    int gap;
    gap = burst_mode ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_real_i    <= dr;
    data_imag_i    <= di;
    twiddle_real_i <= tr;
    twiddle_imag_i <= ti;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // input monitor feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_word(data_real_i, data_imag_i, twiddle_real_i, twiddle_imag_i);
  end

  // output monitor checks each accepted word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(prod_real_o, prod_imag_o);
  end

  // receiver: random ready runs and stalls, one long hold-off to fill the pipe
  initial begin
    bit rx_level;
    int rx_cnt;
    bit held_off;
    rx_level = 1'b0;
    rx_cnt   = 0;
    held_off = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held_off && sb.checked >= 300) begin
        held_off = 1'b1;
        rx_level = 1'b0;
        rx_cnt   = 200;
      end
      while (rx_cnt == 0) begin
        rx_level = !rx_level;
        if (rx_level)
          rx_cnt = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 10);
        else
          rx_cnt = idle_len();
      end
      out_ready_i <= rx_level;
      rx_cnt--;
    end
  end

  // stimulus
  initial begin
    logic [DATA_W-1:0] dr, di, ti;
    logic [TWR_W-1:0]  tr;
    int                sel;
    burst_mode     = 1'b0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    data_real_i    <= '0;
    data_imag_i    <= '0;
    twiddle_real_i <= '0;
    twiddle_imag_i <= '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: extremes, unity, minus-j and their near misses
    send_word(16'h0000, 16'h0000, 17'h00000, 16'h0000);
    send_word(16'h7fff, 16'h7fff, 17'h07fff, 16'h7fff);
    send_word(16'h8000, 16'h8000, 17'h18000, 16'h8000);
    send_word(16'h7fff, 16'h8000, 17'h18000, 16'h7fff);
    send_word(16'h8000, 16'h7fff, 17'h07fff, 16'h8000);
    send_word(16'hffff, 16'hffff, 17'h1ffff, 16'hffff);
    send_word(16'h1234, 16'hfedc, 17'h08000, 16'h0000);
    send_word(16'h8000, 16'h7fff, 17'h08000, 16'h0000);
    send_word(16'h1234, 16'hfedc, 17'h00000, 16'h8000);
    send_word(16'h8000, 16'h8000, 17'h00000, 16'h8000);
    send_word(16'h7fff, 16'h0001, 17'h00000, 16'h8000);
    send_word(16'h4000, 16'hc000, 17'h08000, 16'h0001);
    send_word(16'h7fff, 16'h8000, 17'h08000, 16'h8000);
    send_word(16'h5555, 16'haaaa, 17'h18000, 16'h0000);
    send_word(16'h5555, 16'haaaa, 17'h00000, 16'h8001);
    send_word(16'h0001, 16'hffff, 17'h00001, 16'h0000);
    send_word(16'h4000, 16'h4000, 17'h04000, 16'h4000);
    send_word(16'h8000, 16'h0000, 17'h00000, 16'h7fff);
    send_word(16'haaaa, 16'h5555, 17'h1aaaa, 16'h5555);
    send_word(16'h0001, 16'h0001, 17'h07fff, 16'h8000);

    // random: mostly general products, some shortcut twiddles
    for (int n = 0; n < N_RANDOM; n++) begin
      burst_mode = ((n / 64) % 4) == 3;
      dr  = rand_frac();
      di  = rand_frac();
      sel = $urandom_range(19);
      case (sel)
        0: begin
          tr = 17'(HALF);
          ti = '0;
        end
        1: begin
          tr = '0;
          ti = 16'h8000;
        end
        2: begin
          tr = 17'(HALF);
          ti = rand_frac();
        end
        default: begin
          tr = rand_tw_re();
          ti = rand_frac();
        end
      endcase
      send_word(dr, di, tr, ti);
    end
    in_valid_i <= 1'b0;

    // drain, then give the pipe time to show any stray word
    while (sb.pending_prod_q.size() != 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
